// ----- rtl/arq_pkg.sv -----
// arq_pkg: shared types and codes for the aging request queue
`default_nettype none

package arq_pkg;

    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 5;

    // item kinds carried on the slave tuser
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // request fields, command in the lowest bits
    typedef struct packed {
        logic [2:0]  low_column;
        logic [1:0]  bank_index;
        logic [1:0]  bank_group;
        logic [7:0]  high_column;
        logic [16:0] row_addr;
        logic [1:0]  command;
    } t_req_fields;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        t_req_fields      fields;
    } t_entry;

    // per-transaction control broadcast to every cell
    typedef struct packed {
        logic             tick;
        logic             add;
        logic             remove;
        logic [TAG_W-1:0] tag;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/arq_cell.sv -----
// arq_cell: one queue slot holding a request, its age and a valid bit
`default_nettype none

module arq_cell
    import arq_pkg::*;
#(
    parameter int AGE_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire t_entry              i_new_entry,
    input  wire logic                i_prev_valid,
    input  wire logic                i_next_valid,
    input  wire t_entry              i_next_entry,
    input  wire logic [AGE_BITS-1:0] i_next_age,
    input  wire logic                i_hit,
    output logic                     o_hit,
    output logic                     o_valid,
    output t_entry                   o_entry,
    output logic [AGE_BITS-1:0]      o_age
);

    logic                r_valid;
    t_entry              r_entry;
    logic [AGE_BITS-1:0] r_age;

    logic                n_valid;
    t_entry              n_entry;
    logic [AGE_BITS-1:0] n_age;

    logic w_match;
    logic w_shift;

    assign w_match = r_valid && (r_entry.tag == i_ctrl.tag);
    assign o_hit   = i_hit || w_match;
    // a hit here or nearer the head pulls the neighbour up one slot
    assign w_shift = i_ctrl.remove && o_hit;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        n_age   = r_age;
        if (w_shift) begin
            n_valid = i_next_valid;
            n_entry = i_next_entry;
            n_age   = i_next_age;
        end else if (i_ctrl.add && !r_valid && i_prev_valid) begin
            // first free slot is the tail
            n_valid = 1'b1;
            n_entry = i_new_entry;
            n_age   = '0;
        end else if (i_ctrl.tick && r_valid && (r_age != '1)) begin
            n_age = r_age + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_age   <= n_age;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_age   = r_age;

endmodule

`default_nettype wire

// ----- rtl/aging_request_queue_unit.sv -----
// aging_request_queue_unit: ordered request queue with per-entry age counters
//
// slave channel: one transaction per item; tuser carries the item kind
// (tick, add, remove) and tdata the tag and request fields. master channel:
// one transaction per item carrying a status and the entry count after it.
// the queue is a row of slots, head at slot 0; each slot compares its tag,
// ages itself and takes its neighbour's contents when an entry at or ahead
// of it leaves.
// latency: the result is on the master side the cycle after the slave
// transaction. throughput: one item per cycle while results are taken.
// a single output register sits between the sides: a new item is taken
// whenever that register is empty or being emptied in the same cycle, so a
// stalled receiver holds one result and stops the slave side after that.
// the longest path is the tag compare followed by the head-to-tail hit
// ripple through all slots.
// reset empties the queue and drops any pending result.
`default_nettype none

module aging_request_queue_unit
    import arq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int AGE_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: request_tag, command, row_addr, high_column, bank_group,
    // bank_index, low_column, zero pad
    input  wire logic [71:0] s_axis_tdata,
    // tuser: func
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status, entry_count, zero pad
    output logic [7:0]       m_axis_tdata
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                w_take;
    t_cell_ctrl          w_ctrl;
    t_entry              w_new_entry;
    logic                w_full;
    logic                w_found;

    logic                w_valid [QUEUE_DEPTH:0];
    t_entry              w_entry [QUEUE_DEPTH:0];
    logic [AGE_BITS-1:0] w_age   [QUEUE_DEPTH:0];
    logic                w_hit   [QUEUE_DEPTH:0];

    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [STATUS_W-1:0]    n_status;
    logic [COUNT_OUT_W-1:0] r_count_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    assign w_new_entry.tag    = s_axis_tdata[TAG_W-1:0];
    assign w_new_entry.fields = t_req_fields'(s_axis_tdata[TAG_W+$bits(t_req_fields)-1:TAG_W]);

    assign w_ctrl.tick   = w_take && (s_axis_tuser == FUNC_TICK);
    assign w_ctrl.add    = w_take && (s_axis_tuser == FUNC_ADD) && !w_full;
    assign w_ctrl.remove = w_take && (s_axis_tuser == FUNC_REMOVE);
    assign w_ctrl.tag    = s_axis_tdata[TAG_W-1:0];

    // nothing lies beyond the tail slot
    assign w_valid[QUEUE_DEPTH] = 1'b0;
    assign w_entry[QUEUE_DEPTH] = '0;
    assign w_age[QUEUE_DEPTH]   = '0;
    assign w_hit[0]             = 1'b0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic w_prev_valid;
            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_valid = w_valid[g-1];
            end

            arq_cell #(
                .AGE_BITS (AGE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_new_entry  (w_new_entry),
                .i_prev_valid (w_prev_valid),
                .i_next_valid (w_valid[g+1]),
                .i_next_entry (w_entry[g+1]),
                .i_next_age   (w_age[g+1]),
                .i_hit        (w_hit[g]),
                .o_hit        (w_hit[g+1]),
                .o_valid      (w_valid[g]),
                .o_entry      (w_entry[g]),
                .o_age        (w_age[g])
            );
        end
    endgenerate

    assign w_full  = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign w_found = w_hit[QUEUE_DEPTH];

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        case (s_axis_tuser)
            FUNC_ADD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status    <= n_status;
            r_count_out <= COUNT_OUT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_count_out, r_status};

endmodule

`default_nettype wire

// ----- rtl/arq_checker.sv -----
// arq_checker: port-level checks for the aging request queue, bound to the top level
`default_nettype none

module arq_checker
    import arq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    logic w_in_take;
    assign w_in_take = s_axis_tvalid && s_axis_tready;

    // a reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // an empty output register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("slave stalled with output register empty");

    // a tick always succeeds
    a_tick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && (s_axis_tuser == FUNC_TICK)
        |=> m_axis_tvalid && (m_axis_tdata[1:0] == ST_OK))
        else $error("tick gave a failing status");

    // an add never reports tag not found
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take && (s_axis_tuser == FUNC_ADD)
        |=> m_axis_tvalid && (m_axis_tdata[1:0] != ST_NOT_FOUND))
        else $error("add reported tag not found");

endmodule

bind aging_request_queue_unit arq_checker u_arq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/arq_queue_board_pkg.sv -----
// arq_queue_board_pkg: queue occupancy predictor and result checker for the request queue test
package arq_queue_board_pkg;
    import arq_pkg::*;

    localparam int TB_QUEUE_DEPTH = 16;
    localparam int TB_AGE_BITS    = 16;

    // fourth item kind, the block lets it pass without effect
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count;
    } t_reply;

    class queue_status_board;
        t_entry                 slot_entry[$];   // head at index 0
        logic [TB_AGE_BITS-1:0] slot_age[$];
        t_reply                 pending_replies[$];
        int                     fault_count;

        function new();
            fault_count = 0;
        endfunction

        function void note_request(logic [1:0] func, t_entry req);
            t_reply want;
            int     hit;
            want.status = ST_OK;
            hit = -1;
            case (func)
                FUNC_TICK: begin
                    foreach (slot_age[i])
                        if (slot_age[i] != '1)
                            slot_age[i] = slot_age[i] + 1'b1;
                end
                FUNC_ADD: begin
                    if (slot_entry.size() >= TB_QUEUE_DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        slot_entry.push_back(req);
                        slot_age.push_back('0);
                    end
                end
                FUNC_REMOVE: begin
                    // only the match nearest the head goes
                    foreach (slot_entry[i])
                        if (hit < 0 && slot_entry[i].tag == req.tag)
                            hit = i;
                    if (hit < 0) begin
                        want.status = ST_NOT_FOUND;
                    end else begin
                        slot_entry.delete(hit);
                        slot_age.delete(hit);
                    end
                end
                default: ;
            endcase
            want.count = COUNT_OUT_W'(slot_entry.size());
            pending_replies.push_back(want);
        endfunction

        function void check_reply(logic [7:0] data);
            t_reply got;
            t_reply want;
            got.status = data[STATUS_W-1:0];
            got.count  = data[STATUS_W+COUNT_OUT_W-1:STATUS_W];
            if (pending_replies.size() == 0) begin
                $display("%0t: result with nothing pending: status %0d count %0d",
                         $time, got.status, got.count);
                fault_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got.status);
                fault_count++;
            end
            if (got.count !== want.count) begin
                $display("%0t: entry count mismatch: expected %0d actual %0d",
                         $time, want.count, got.count);
                fault_count++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/aging_request_queue_unit_test.sv -----
// aging_request_queue_unit_test: stream-level test of the aging request queue against a predictor
module aging_request_queue_unit_test;
    import arq_pkg::*;
    import arq_queue_board_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 400_000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    queue_status_board board = new();

    aging_request_queue_unit #(
        .QUEUE_DEPTH (TB_QUEUE_DEPTH),
        .AGE_BITS    (TB_AGE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // result side: values sampled here are the ones before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_reply(m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_entry random_entry();
        logic [63:0] r;
        t_entry      e;
        r = {$urandom, $urandom};
        e.tag    = $urandom;
        e.fields = r[33:0];
        return e;
    endfunction

    // one transaction on the slave side; tvalid stays up for a following item
    task automatic send_item(input logic [1:0] func, input t_entry ent);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'b0, ent.fields, ent.tag};
        do @(posedge i_clk); while (!s_tready);
        board.note_request(func, ent);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending_replies.size() != 0);
    endtask

    // mostly adds and removes of queued tags, so the queue swings between empty and full
    task automatic run_phase(input int items);
        int         done;
        int         add_pct;
        int         roll;
        int         n;
        logic [1:0] func;
        t_entry     ent;
        done = 0;
        add_pct = 50;
        while (done < items) begin
            if (done % 50 == 0)
                add_pct = $urandom_range(30, 65);
            ent = random_entry();
            if ($urandom_range(1))
                ent.tag = 32'($urandom_range(7));   // small pool gives duplicate tags
            roll = $urandom_range(99);
            n = board.slot_entry.size();
            if (roll < 4) begin
                func = FUNC_IGNORED;
            end else if (roll < 20) begin
                func = FUNC_TICK;
            end else if (roll < 20 + add_pct) begin
                func = FUNC_ADD;
            end else begin
                func = FUNC_REMOVE;
                if (n != 0 && $urandom_range(9) < 8)
                    ent.tag = board.slot_entry[$urandom_range(n - 1)].tag;
            end
            send_item(func, ent);
            if (func != FUNC_IGNORED)
                done++;
        end
    endtask

    initial begin
        t_entry ent;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        stall_pct     = 71;

        ent.tag    = '0;
        ent.fields = '0;
        send_item(FUNC_REMOVE, ent);     // remove from an empty queue
        send_item(FUNC_TICK, ent);
        send_item(FUNC_IGNORED, ent);
        send_item(FUNC_ADD, ent);
        ent.tag    = '1;
        ent.fields = '1;
        send_item(FUNC_ADD, ent);
        ent = random_entry();
        ent.tag = '0;
        send_item(FUNC_ADD, ent);        // same tag as the head
        while (board.slot_entry.size() < TB_QUEUE_DEPTH) begin
            ent = random_entry();
            send_item(FUNC_ADD, ent);
        end
        ent = random_entry();
        send_item(FUNC_ADD, ent);        // dropped, queue full
        send_item(FUNC_TICK, ent);
        send_item(FUNC_IGNORED, ent);
        ent.tag = '0;
        send_item(FUNC_REMOVE, ent);     // head, first of the duplicates
        send_item(FUNC_REMOVE, ent);
        ent.tag = board.slot_entry[board.slot_entry.size() - 1].tag;
        send_item(FUNC_REMOVE, ent);     // tail
        ent.tag = board.slot_entry[board.slot_entry.size() / 2].tag;
        send_item(FUNC_REMOVE, ent);     // middle, entries behind close up
        ent.tag = '1;
        send_item(FUNC_REMOVE, ent);
        send_item(FUNC_REMOVE, ent);     // already gone

        run_phase(330);
        drain_results();

        send_idle_pct = 71;
        stall_pct     = 35;
        run_phase(330);
        drain_results();

        send_idle_pct = 0;
        stall_pct     = 0;
        run_phase(340);

        // short tick run back to back, then take the head out
        ent = random_entry();
        send_item(FUNC_ADD, ent);
        repeat (20)
            send_item(FUNC_TICK, ent);
        ent.tag = board.slot_entry[0].tag;
        send_item(FUNC_REMOVE, ent);
        send_item(FUNC_TICK, ent);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (board.fault_count == 0 && board.pending_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
